// ===== hw/rtl/ray_box_intersect_assert.svh =====
// Assertion macros used by the ray/box intersection top level
`ifndef RAY_BOX_INTERSECT_ASSERT_SVH
`define RAY_BOX_INTERSECT_ASSERT_SVH

// implication checked at every clock edge outside reset
`define RBI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// invariant checked at every clock edge outside reset
`define RBI_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

// ===== hw/rtl/rbi_pkg.sv =====
// Types, constants and latencies of the ray/box intersection pipeline
package rbi_pkg;

	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int QUO_BITS   = COORD_BITS - 1;

	localparam int CLS_LAT   = 3;
	localparam int DIV_LAT   = QUO_BITS + 2;
	localparam int RES_LAT   = 6;
	localparam int TOTAL_LAT = CLS_LAT + DIV_LAT + RES_LAT;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef coord_t [2:0] vec3_t;

	localparam coord_t CMAX   = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t CMIN   = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam coord_t T_NONE = coord_t'(-(longint'(1) << FRAC_BITS));

	typedef struct packed {
		coord_t box_min_x;
		coord_t box_min_y;
		coord_t box_min_z;
		coord_t box_max_x;
		coord_t box_max_y;
		coord_t box_max_z;
		coord_t ray_org_x;
		coord_t ray_org_y;
		coord_t ray_org_z;
		coord_t ray_dir_x;
		coord_t ray_dir_y;
		coord_t ray_dir_z;
	} req_t;

	typedef struct packed {
		logic   hit;
		coord_t hit_x;
		coord_t hit_y;
		coord_t hit_z;
	} rsp_t;

	// per-item data that rides alongside the divider
	typedef struct packed {
		logic  org_in;
		vec3_t lo;
		vec3_t hi;
		vec3_t org;
		vec3_t dir;
		vec3_t plane;
	} side_t;

	typedef struct packed {
		logic                  en;
		logic                  neg;
		logic [COORD_BITS:0]   num;
		logic [COORD_BITS-1:0] den;
	} div_in_t;

	typedef div_in_t [2:0] div_in3_t;

endpackage

// ===== hw/rtl/ray_box_intersect.sv =====
// Ray / axis-aligned box intersection, fully pipelined top level
//
//  channel   handshake            word
//  request   start (busy low)     req : rbi_pkg::req_t
//  result    done strobe          rsp : rbi_pkg::rsp_t
//
// One word is taken every cycle; busy never rises.
// The divider resolves one quotient bit per stage in each of three lanes.
// Reset clears only the valid bits; data registers hold whatever they held.
// The result strobe lasts one cycle and cannot be stalled.
`include "ray_box_intersect_assert.svh"

module ray_box_intersect (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  rbi_pkg::req_t  req,
	output logic           done,
	output rbi_pkg::rsp_t  rsp
);
	import rbi_pkg::*;

	logic cls_vld;
	side_t cls_side;
	div_in3_t div_op;
	vec3_t t_vec;

	side_t side_q [DIV_LAT];
	logic [DIV_LAT-1:0] vld_q;

	assign busy = 1'b0;

	rbi_classify u_cls (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_vld (start && !busy),
		.item     (req),
		.cls_vld  (cls_vld),
		.side     (cls_side),
		.div_op   (div_op)
	);

	for (genvar i = 0; i < 3; i++) begin : g_lane
		rbi_div u_div (
			.clk (clk),
			.op  (div_op[i]),
			.t   (t_vec[i])
		);
	end

	// side data waits out the divider latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[DIV_LAT-2:0], cls_vld};
		end
	end

	always_ff @(posedge clk) begin
		side_q[0] <= cls_side;
		for (int k = 1; k < DIV_LAT; k++) begin
			side_q[k] <= side_q[k-1];
		end
	end

	rbi_resolve u_res (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_vld (vld_q[DIV_LAT-1]),
		.side     (side_q[DIV_LAT-1]),
		.t        (t_vec),
		.done     (done),
		.rsp      (rsp)
	);

	`RBI_ASSERT_IMP(a_done_latency, done, $past(start && !busy, TOTAL_LAT), "result word without accepted request")
	`RBI_ASSERT_IMP(a_side_align, vld_q[DIV_LAT-1], $past(cls_vld, DIV_LAT), "side data out of step with divider")
	`RBI_ASSERT_ALWAYS(a_miss_zero, !done || rsp.hit || (rsp.hit_x == '0 && rsp.hit_y == '0 && rsp.hit_z == '0), "miss with nonzero point")

endmodule

// ===== hw/rtl/rbi_classify.sv =====
// Slab classification, plane distance and operand magnitudes (three stages)
module rbi_classify (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_vld,
	input  rbi_pkg::req_t   item,
	output logic            cls_vld,
	output rbi_pkg::side_t  side,
	output rbi_pkg::div_in3_t div_op
);
	import rbi_pkg::*;

	localparam int CW = COORD_BITS;

	vec3_t lo_c, hi_c, org_c, dir_c, plane_c;
	logic [2:0] out_c;

	logic vld_s1, vld_s2, vld_s3;
	side_t side_s1, side_s2, side_s3;
	logic [2:0] out_s1;
	logic [2:0] en_s2, dneg_s2;
	logic [2:0][CW:0] diff_s2;
	div_in3_t div_s3;

	always_comb begin
		lo_c  = {item.box_min_z, item.box_min_y, item.box_min_x};
		hi_c  = {item.box_max_z, item.box_max_y, item.box_max_x};
		org_c = {item.ray_org_z, item.ray_org_y, item.ray_org_x};
		dir_c = {item.ray_dir_z, item.ray_dir_y, item.ray_dir_x};
		for (int i = 0; i < 3; i++) begin
			if ($signed(org_c[i]) < $signed(lo_c[i])) begin
				plane_c[i] = lo_c[i];
				out_c[i] = 1'b1;
			end else if ($signed(org_c[i]) > $signed(hi_c[i])) begin
				plane_c[i] = hi_c[i];
				out_c[i] = 1'b1;
			end else begin
				plane_c[i] = '0;
				out_c[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= item_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.org_in <= ~|out_c;
		side_s1.lo <= lo_c;
		side_s1.hi <= hi_c;
		side_s1.org <= org_c;
		side_s1.dir <= dir_c;
		side_s1.plane <= plane_c;
		out_s1 <= out_c;

		side_s2 <= side_s1;
		for (int i = 0; i < 3; i++) begin
			diff_s2[i] <= {side_s1.plane[i][CW-1], side_s1.plane[i]}
				- {side_s1.org[i][CW-1], side_s1.org[i]};
			en_s2[i] <= out_s1[i] && (side_s1.dir[i] != '0);
			dneg_s2[i] <= side_s1.dir[i][CW-1];
		end

		side_s3 <= side_s2;
		for (int i = 0; i < 3; i++) begin
			div_s3[i].en <= en_s2[i];
			div_s3[i].neg <= diff_s2[i][CW] ^ dneg_s2[i];
			div_s3[i].num <= diff_s2[i][CW] ? ((CW+1)'(0) - diff_s2[i]) : diff_s2[i];
			div_s3[i].den <= dneg_s2[i] ? (CW'(0) - side_s2.dir[i]) : side_s2.dir[i];
		end
	end

	assign cls_vld = vld_s3;
	assign side = side_s3;
	assign div_op = div_s3;

endmodule

// ===== hw/rtl/rbi_div.sv =====
// Pipelined restoring divider: floor(num * 2^F / den), signed and saturated; T_NONE when disabled
module rbi_div (
	input  logic              clk,
	input  rbi_pkg::div_in_t  op,
	output rbi_pkg::coord_t   t
);
	import rbi_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int FB = FRAC_BITS;
	localparam int QB = QUO_BITS;
	localparam int WW = 2 * CW + FB;
	localparam int OW = 2 * CW + 1;
	localparam int SH = CW - 1 - FB;

	logic [WW-1:0] rem_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	logic [CW-1:0] den_s [QB+1];
	logic [QB:0]   neg_s, en_s, ovf_s;
	coord_t        t_s;

	// quotient would not fit below 2^(CW-1) iff num >= den * 2^(CW-1-F)
	always_ff @(posedge clk) begin
		rem_s[0] <= WW'(op.num) << FB;
		quo_s[0] <= '0;
		den_s[0] <= op.den;
		neg_s[0] <= op.neg;
		en_s[0] <= op.en;
		ovf_s[0] <= OW'(op.num) >= (OW'(op.den) << SH);
	end

	for (genvar k = 1; k <= QB; k++) begin : g_step
		localparam int BI = QB - k;
		logic [WW-1:0] trial;
		logic take;

		assign trial = WW'(den_s[k-1]) << BI;
		assign take = rem_s[k-1] >= trial;

		always_ff @(posedge clk) begin
			rem_s[k] <= take ? (rem_s[k-1] - trial) : rem_s[k-1];
			quo_s[k] <= quo_s[k-1] | (take ? (QB'(1) << BI) : QB'(0));
			den_s[k] <= den_s[k-1];
			neg_s[k] <= neg_s[k-1];
			en_s[k] <= en_s[k-1];
			ovf_s[k] <= ovf_s[k-1];
		end
	end

	// negative results round toward minus infinity
	always_ff @(posedge clk) begin
		if (!en_s[QB]) begin
			t_s <= T_NONE;
		end else if (ovf_s[QB]) begin
			t_s <= neg_s[QB] ? CMIN : CMAX;
		end else if (neg_s[QB]) begin
			t_s <= coord_t'(0) - coord_t'(quo_s[QB]) - coord_t'(rem_s[QB] != '0);
		end else begin
			t_s <= coord_t'(quo_s[QB]);
		end
	end

	assign t = t_s;

endmodule

// ===== hw/rtl/rbi_resolve.sv =====
// Winner select, hit point product, saturation and box check (six stages)
module rbi_resolve (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_vld,
	input  rbi_pkg::side_t  side,
	input  rbi_pkg::vec3_t  t,
	output logic            done,
	output rbi_pkg::rsp_t   rsp
);
	import rbi_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int FB = FRAC_BITS;
	localparam int PW = 2 * CW - 1;
	localparam int HW = PW - FB;
	localparam int SW = CW + 3;

	typedef struct packed {
		side_t      side;
		logic [1:0] win;
		coord_t     tw;
	} meta_t;

	logic [1:0] w01_c, win_c;
	coord_t t01_c, tw_c;
	logic [2:0][CW-1:0] dmag_c;
	logic [2:0][HW-1:0] hpart_c;
	logic [2:0] big_c;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5;
	logic [2:0][CW-1:0] dmag_s1;
	logic [2:0][PW-1:0] prod_s2;
	logic [2:0][CW:0] res_s3;
	logic [2:0] frac_s3;
	logic signed [2:0][SW-1:0] sum_s4;
	vec3_t c_s5;
	rsp_t rsp_s6;

	logic [2:0] ok_c;
	logic hit_c;
	vec3_t pt_c;

	always_comb begin
		w01_c = ($signed(t[0]) < $signed(t[1])) ? 2'd1 : 2'd0;
		t01_c = ($signed(t[0]) < $signed(t[1])) ? t[1] : t[0];
		if ($signed(t01_c) < $signed(t[2])) begin
			win_c = 2'd2;
			tw_c = t[2];
		end else begin
			win_c = w01_c;
			tw_c = t01_c;
		end
		for (int i = 0; i < 3; i++) begin
			dmag_c[i] = side.dir[i][CW-1] ? (CW'(0) - side.dir[i]) : side.dir[i];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			hpart_c[i] = HW'(prod_s2[i] >> FB);
			big_c[i] = hpart_c[i] > (HW'(1) << CW);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ok_c[i] = (meta_s5.win == 2'(i))
				|| (($signed(c_s5[i]) >= $signed(meta_s5.side.lo[i]))
				&& ($signed(c_s5[i]) <= $signed(meta_s5.side.hi[i])));
		end
		hit_c = meta_s5.side.org_in || (!meta_s5.tw[CW-1] && (&ok_c));
		for (int i = 0; i < 3; i++) begin
			if (!hit_c) begin
				pt_c[i] = '0;
			end else if (meta_s5.side.org_in) begin
				pt_c[i] = meta_s5.side.org[i];
			end else if (meta_s5.win == 2'(i)) begin
				pt_c[i] = meta_s5.side.plane[i];
			end else begin
				pt_c[i] = c_s5[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= item_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		meta_s1.side <= side;
		meta_s1.win <= win_c;
		meta_s1.tw <= tw_c;
		dmag_s1 <= dmag_c;

		// t is only used when non-negative, so its sign bit is dropped
		meta_s2 <= meta_s1;
		for (int i = 0; i < 3; i++) begin
			prod_s2[i] <= PW'(meta_s1.tw[CW-2:0]) * PW'(dmag_s1[i]);
		end

		// magnitude capped at 2^CW, fraction kept for the floor on negative dir
		meta_s3 <= meta_s2;
		for (int i = 0; i < 3; i++) begin
			res_s3[i] <= big_c[i] ? {1'b1, CW'(0)} : hpart_c[i][CW:0];
			frac_s3[i] <= !big_c[i] && (prod_s2[i][FB-1:0] != '0);
		end

		// on negative dir, org - (res + frac) folded into one add: org + ~res + !frac
		meta_s4 <= meta_s3;
		for (int i = 0; i < 3; i++) begin
			sum_s4[i] <= SW'(meta_s3.side.org[i])
				+ (meta_s3.side.dir[i][CW-1] ? ~SW'(res_s3[i]) : SW'(res_s3[i]))
				+ SW'(meta_s3.side.dir[i][CW-1] && !frac_s3[i]);
		end

		meta_s5 <= meta_s4;
		for (int i = 0; i < 3; i++) begin
			if ($signed(sum_s4[i]) > $signed(SW'(CMAX))) begin
				c_s5[i] <= CMAX;
			end else if ($signed(sum_s4[i]) < $signed(SW'(CMIN))) begin
				c_s5[i] <= CMIN;
			end else begin
				c_s5[i] <= sum_s4[i][CW-1:0];
			end
		end

		rsp_s6.hit <= hit_c;
		rsp_s6.hit_x <= pt_c[0];
		rsp_s6.hit_y <= pt_c[1];
		rsp_s6.hit_z <= pt_c[2];
	end

	assign done = vld_s6;
	assign rsp = rsp_s6;

endmodule
